### rtl/jmp_pkg.sv
// Shared types and constants of the joint motion profile block.
// No dependencies; every other file in rtl refers to this package by scoped names.
`timescale 1ns / 1ps
package jmp_pkg;

   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_POSITION = 2'd1;

   localparam int unsigned MS_PER_S     = 1000;
   localparam int unsigned CURRENT_BASE = 50;
   localparam int unsigned CURRENT_MAX  = 32767;
   localparam logic [63:0] ROOT_TOP     = 64'h4000_0000_0000_0000;
   localparam logic [63:0] ROOT_SAT     = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CSR_MIN_POS,
      CSR_MAX_POS,
      CSR_ACCEL,
      CSR_TIMEOUT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_WATCH, ST_N_VEL, ST_N_STEP, ST_P_ERR, ST_P_ROOT,
      ST_P_DV, ST_P_VEL, ST_P_SGO, ST_P_STEP, ST_P_FIX, ST_CLAMP, ST_EST, ST_DONE
   } jmp_state_type;

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   typedef struct packed {
      logic               command;
      logic [1:0]         new_mode;
      logic signed [31:0] target_position;
      logic [30:0]        speed_limit;
      logic [31:0]        sequence_number;
      logic [15:0]        tick_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         mode_now;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic [14:0]        current_estimate;
      logic [31:0]        last_sequence;
      logic               limit_error;
      logic               peer_lost;
      logic [31:0]        timeout_count;
   } rsp_type;

   // launch of the serial multiply / divide-by-1000 unit
   typedef struct packed {
      logic        start;
      logic        div;
      logic [32:0] a;
      logic [32:0] b;
   } md_op_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
      logic [47:0] quotient;
   } md_res_type;

endpackage

### rtl/jmp_muldiv.sv
// Bit-serial shift-add multiplier with an optional restoring divide by 1000.
// Depends on jmp_pkg (operation and result structs, state enum).
`timescale 1ns / 1ps
module jmp_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  jmp_pkg::md_op_type  op,
   output jmp_pkg::md_res_type res
);
   localparam int MUL_STEPS = 33;
   localparam int DIV_STEPS = 48;
   localparam logic [10:0] DIVISOR = 11'(jmp_pkg::MS_PER_S);

   jmp_pkg::md_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic        done_ff, done_in;
   logic [32:0] a_ff, a_in;
   logic [33:0] hi_ff, hi_in;
   logic [32:0] lo_ff, lo_in;
   logic [47:0] dq_ff, dq_in;
   logic [9:0]  rem_ff, rem_in;
   logic [33:0] sum;
   logic [10:0] trial;
   logic        ge;
   logic [63:0] prod;

   assign prod  = {hi_ff[30:0], lo_ff};
   assign sum   = hi_ff + (lo_ff[0] ? {1'b0, a_ff} : 34'd0);
   assign trial = {rem_ff, dq_ff[47]};
   assign ge    = trial >= DIVISOR;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jmp_pkg::MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      a_in     = a_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         jmp_pkg::MD_IDLE: begin
            if (op.start) begin
               a_in     = op.a;
               lo_in    = op.b;
               hi_in    = '0;
               div_in   = op.div;
               cnt_in   = '0;
               state_in = jmp_pkg::MD_MUL;
            end
         end
         jmp_pkg::MD_MUL: begin
            // add and shift one multiplier bit
            hi_in  = {1'b0, sum[33:1]};
            lo_in  = {sum[0], lo_ff[32:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               cnt_in = '0;
               if (div_ff) begin
                  state_in = jmp_pkg::MD_DIV;
               end else begin
                  state_in = jmp_pkg::MD_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
         jmp_pkg::MD_DIV: begin
            if (cnt_ff == 6'd0) begin
               // load the dividend from the finished product
               dq_in  = prod[47:0];
               rem_in = '0;
               cnt_in = 6'd1;
            end else begin
               rem_in = ge ? 10'(trial - DIVISOR) : trial[9:0];
               dq_in  = {dq_ff[46:0], ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'(DIV_STEPS)) begin
                  state_in = jmp_pkg::MD_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
         default: state_in = jmp_pkg::MD_IDLE;
      endcase
   end

   assign res.done     = done_ff;
   assign res.product  = prod;
   assign res.quotient = dq_ff;
endmodule

### rtl/jmp_isqrt.sv
// Floor square root of a 64-bit operand, one result bit per cycle.
// Depends on jmp_pkg (ROOT_TOP).
`timescale 1ns / 1ps
module jmp_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [31:0] root
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] rb;
   logic        ge;

   assign rb = r_ff + b_ff;
   assign ge = x_ff >= rb;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      if (!busy_ff) begin
         if (start) begin
            x_in    = operand;
            r_in    = '0;
            b_in    = jmp_pkg::ROOT_TOP;
            busy_in = 1'b1;
         end
      end else begin
         x_in = ge ? x_ff - rb : x_ff;
         r_in = ge ? (r_ff >> 1) + b_ff : r_ff >> 1;
         b_in = b_ff >> 2;
         if (b_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

### rtl/joint_motion_profile_top.sv
// Joint motion profile: sequencer, state registers and result register.
// Depends on jmp_pkg, jmp_muldiv and jmp_isqrt.
`timescale 1ns / 1ps
// Usage:
//   req_*  : one request is a motion command (command = 0) or a time tick
//            (command = 1) of tick_ms milliseconds. A request is taken when
//            req_valid and req_ready are both high; req_ready is high while the
//            sequencer is idle.
//   rsp_*  : exactly one result per request, held in an output register until
//            rsp_ready takes it. The next request is accepted while a result
//            waits; the sequencer only stalls when it has a second result ready.
//   csr_*  : write-only registers (min/max position, acceleration, timeout); the
//            user must write them only while the block is idle; the block has no check for this.
// Work per request, done on the bit-serial multiply/divide unit and the root unit:
//   command or zero tick : one divide (for the current figure)
//   tick, braking        : three multiply/divide passes
//   tick, position mode  : product, root, three passes
// The next request is taken only after the last one reaches the result register.
// Reset clears all joint state and loads the register defaults; the block is
// ready in the cycle after reset.
module joint_motion_profile_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jmp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   jmp_pkg::jmp_state_type state_ff, state_in;
   jmp_pkg::req_type       req_ff, req_in;
   jmp_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // configuration
   logic signed [31:0] min_ff, max_ff;
   logic [30:0]        accel_ff;
   logic [31:0]        tout_ff;

   // joint state
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] tgt_ff, tgt_in;
   logic [30:0]        spd_ff, spd_in;
   logic [1:0]         mode_ff, mode_in;
   logic [31:0]        elap_ff, elap_in;
   logic               limit_ff, limit_in;
   logic               lost_ff, lost_in;
   logic [31:0]        tally_ff, tally_in;
   logic [31:0]        seq_ff, seq_in;

   // working registers
   logic signed [32:0] err_ff, err_in;
   logic signed [32:0] vwant_ff, vwant_in;
   logic signed [39:0] step_ff, step_in;
   logic [14:0]        cur_ff, cur_in;

   jmp_pkg::md_op_type  md_op;
   jmp_pkg::md_res_type md_res;
   logic                sq_start, sq_done;
   logic [63:0]         sq_operand;
   logic [31:0]         sq_root;

   jmp_muldiv u_muldiv (
      .clock(clock), .reset(reset), .op(md_op), .res(md_res)
   );

   jmp_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start), .operand(sq_operand),
      .done(sq_done), .root(sq_root)
   );

   function automatic logic signed [31:0] clamp_pos(input logic signed [40:0] v,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = v[31:0];
      if (v < 41'(lo)) r = lo;
      else if (v > 41'(hi)) r = hi;
      return r;
   endfunction

   assign req_ready = (state_ff == jmp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= -32'sd180000;
         max_ff   <= 32'sd180000;
         accel_ff <= 31'd1;
         tout_ff  <= '0;
      end else if (csr_we) begin
         unique case (jmp_pkg::csr_index_type'(csr_index))
            jmp_pkg::CSR_MIN_POS: min_ff <= csr_wdata;
            jmp_pkg::CSR_MAX_POS: max_ff <= csr_wdata;
            // a zero acceleration is stored as one
            jmp_pkg::CSR_ACCEL:
               accel_ff <= (csr_wdata[30:0] == 31'd0) ? 31'd1 : csr_wdata[30:0];
            jmp_pkg::CSR_TIMEOUT: tout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jmp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         tgt_ff       <= '0;
         spd_ff       <= '0;
         mode_ff      <= jmp_pkg::MODE_DISABLED;
         elap_ff      <= '0;
         limit_ff     <= 1'b0;
         lost_ff      <= 1'b0;
         tally_ff     <= '0;
         seq_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         tgt_ff       <= tgt_in;
         spd_ff       <= spd_in;
         mode_ff      <= mode_in;
         elap_ff      <= elap_in;
         limit_ff     <= limit_in;
         lost_ff      <= lost_in;
         tally_ff     <= tally_in;
         seq_ff       <= seq_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      err_ff   <= err_in;
      vwant_ff <= vwant_in;
      step_ff  <= step_in;
      cur_ff   <= cur_in;
   end

   // combinational helpers
   logic [32:0]        vabs;
   logic [32:0]        eabs_c;
   logic signed [32:0] err_c;
   logic [32:0]        elap_sum;
   logic [31:0]        elap_sat;
   logic               pos_mode;
   logic [47:0]        dv;
   logic [31:0]        vlim;
   logic signed [33:0] v34, w34, vnew;
   logic [33:0]        diff;
   logic signed [39:0] e40, s1, s2;
   logic               over;
   logic signed [40:0] pos_sum;

   always_comb begin
      vabs     = vel_ff[31] ? (33'd0 - {1'b1, vel_ff}) : {1'b0, vel_ff};
      err_c    = {tgt_ff[31], tgt_ff} - {pos_ff[31], pos_ff};
      eabs_c   = err_c[32] ? (33'd0 - err_c) : err_c;
      elap_sum = {1'b0, elap_ff} + {17'd0, req_ff.tick_ms};
      elap_sat = elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0];
      pos_mode = (mode_ff == jmp_pkg::MODE_POSITION);
      dv       = (md_res.quotient == 48'd0) ? 48'd1 : md_res.quotient;
      vlim     = (sq_root < {1'b0, spd_ff}) ? sq_root : {1'b0, spd_ff};
      v34      = 34'(vel_ff);
      w34      = 34'(vwant_ff);
      diff     = (w34 > v34) ? 34'(w34 - v34) : 34'(v34 - w34);
      if ({14'd0, diff} > dv) vnew = (w34 > v34) ? v34 + $signed(dv[33:0])
                                                 : v34 - $signed(dv[33:0]);
      else vnew = w34;
      e40      = 40'(err_ff);
      over     = (e40 > 40'sd0 && step_ff > e40) || (e40 < 40'sd0 && step_ff < e40);
      s1       = over ? e40 : step_ff;
      if (s1 == 40'sd0 && e40 != 40'sd0) s2 = e40[39] ? -40'sd1 : 40'sd1;
      else s2 = s1;
      pos_sum  = 41'(pos_ff) + 41'(step_ff);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      tgt_in       = tgt_ff;
      spd_in       = spd_ff;
      mode_in      = mode_ff;
      elap_in      = elap_ff;
      limit_in     = limit_ff;
      lost_in      = lost_ff;
      tally_in     = tally_ff;
      seq_in       = seq_ff;
      err_in       = err_ff;
      vwant_in     = vwant_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      md_op        = '0;
      sq_start     = 1'b0;
      sq_operand   = (md_res.product[63:62] != 2'b00) ? jmp_pkg::ROOT_SAT
                                                      : {md_res.product[62:0], 1'b0};

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         jmp_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = jmp_pkg::ST_DECODE;
            end
         end
         jmp_pkg::ST_DECODE: begin
            if (!req_ff.command) begin
               seq_in  = req_ff.sequence_number;
               elap_in = '0;
               mode_in = req_ff.new_mode;
               lost_in = 1'b0;
               if (req_ff.new_mode == jmp_pkg::MODE_POSITION) begin
                  spd_in   = req_ff.speed_limit;
                  limit_in = (req_ff.target_position < min_ff) ||
                             (req_ff.target_position > max_ff);
                  tgt_in   = clamp_pos(41'(req_ff.target_position), min_ff, max_ff);
               end
            end
            if (!req_ff.command || req_ff.tick_ms == 16'd0) begin
               md_op    = '{start: 1'b1, div: 1'b1, a: vabs, b: 33'd1};
               state_in = jmp_pkg::ST_EST;
            end else begin
               state_in = jmp_pkg::ST_WATCH;
            end
         end
         jmp_pkg::ST_WATCH: begin
            // command watchdog, then pick braking or position control
            if (pos_mode && tout_ff != 32'd0) begin
               elap_in = elap_sat;
               if (elap_sat > tout_ff) begin
                  mode_in  = jmp_pkg::MODE_DISABLED;
                  lost_in  = 1'b1;
                  tally_in = (tally_ff == 32'hFFFF_FFFF) ? tally_ff : tally_ff + 32'd1;
               end
            end
            if (mode_in != jmp_pkg::MODE_POSITION) begin
               md_op    = '{start: 1'b1, div: 1'b1, a: {2'b00, accel_ff},
                            b: {17'd0, req_ff.tick_ms}};
               state_in = jmp_pkg::ST_N_VEL;
            end else begin
               state_in = jmp_pkg::ST_P_ERR;
            end
         end
         jmp_pkg::ST_N_VEL: begin
            if (md_res.done) begin
               // brake: shrink the magnitude by a*dt/1000, keep the sign
               if ({15'd0, vabs} <= md_res.quotient) begin
                  vel_in = '0;
                  md_op  = '{start: 1'b1, div: 1'b1, a: 33'd0,
                             b: {17'd0, req_ff.tick_ms}};
               end else begin
                  vel_in = vel_ff[31] ? vel_ff + $signed(md_res.quotient[31:0])
                                      : vel_ff - $signed(md_res.quotient[31:0]);
                  md_op  = '{start: 1'b1, div: 1'b1, a: vabs - md_res.quotient[32:0],
                             b: {17'd0, req_ff.tick_ms}};
               end
               state_in = jmp_pkg::ST_N_STEP;
            end
         end
         jmp_pkg::ST_N_STEP: begin
            if (md_res.done) begin
               step_in  = vel_ff[31] ? 40'sd0 - $signed({1'b0, md_res.quotient[38:0]})
                                     : $signed({1'b0, md_res.quotient[38:0]});
               state_in = jmp_pkg::ST_CLAMP;
            end
         end
         jmp_pkg::ST_P_ERR: begin
            err_in   = err_c;
            md_op    = '{start: 1'b1, div: 1'b0, a: {2'b00, accel_ff}, b: eabs_c};
            state_in = jmp_pkg::ST_P_ROOT;
         end
         jmp_pkg::ST_P_ROOT: begin
            if (md_res.done) begin
               sq_start = 1'b1;
               state_in = jmp_pkg::ST_P_DV;
            end
         end
         jmp_pkg::ST_P_DV: begin
            if (sq_done) begin
               vwant_in = (err_ff > 33'sd0) ? $signed({1'b0, vlim})
                                            : 33'sd0 - $signed({1'b0, vlim});
               md_op    = '{start: 1'b1, div: 1'b1, a: {2'b00, accel_ff},
                            b: {17'd0, req_ff.tick_ms}};
               state_in = jmp_pkg::ST_P_VEL;
            end
         end
         jmp_pkg::ST_P_VEL: begin
            if (md_res.done) begin
               vel_in   = vnew[31:0];
               state_in = jmp_pkg::ST_P_SGO;
            end
         end
         jmp_pkg::ST_P_SGO: begin
            md_op    = '{start: 1'b1, div: 1'b1, a: vabs, b: {17'd0, req_ff.tick_ms}};
            state_in = jmp_pkg::ST_P_STEP;
         end
         jmp_pkg::ST_P_STEP: begin
            if (md_res.done) begin
               step_in  = vel_ff[31] ? 40'sd0 - $signed({1'b0, md_res.quotient[38:0]})
                                     : $signed({1'b0, md_res.quotient[38:0]});
               state_in = jmp_pkg::ST_P_FIX;
            end
         end
         jmp_pkg::ST_P_FIX: begin
            // no overshoot; crawl the last millidegree; stop on arrival
            step_in = s2;
            if (over || s2 == e40) vel_in = '0;
            state_in = jmp_pkg::ST_CLAMP;
         end
         jmp_pkg::ST_CLAMP: begin
            pos_in   = clamp_pos(pos_sum, min_ff, max_ff);
            md_op    = '{start: 1'b1, div: 1'b1, a: vabs, b: 33'd1};
            state_in = jmp_pkg::ST_EST;
         end
         jmp_pkg::ST_EST: begin
            if (md_res.done) begin
               if (!pos_mode) cur_in = '0;
               else if (md_res.quotient >
                        48'(jmp_pkg::CURRENT_MAX - jmp_pkg::CURRENT_BASE))
                  cur_in = 15'(jmp_pkg::CURRENT_MAX);
               else cur_in = 15'(md_res.quotient[14:0] + 15'(jmp_pkg::CURRENT_BASE));
               state_in = jmp_pkg::ST_DONE;
            end
         end
         jmp_pkg::ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.mode_now         = mode_ff;
               rsp_in.position         = pos_ff;
               rsp_in.velocity         = vel_ff;
               rsp_in.current_estimate = cur_ff;
               rsp_in.last_sequence    = seq_ff;
               rsp_in.limit_error      = limit_ff;
               rsp_in.peer_lost        = lost_ff;
               rsp_in.timeout_count    = tally_ff;
               rsp_valid_in            = 1'b1;
               state_in                = jmp_pkg::ST_IDLE;
            end
         end
         default: state_in = jmp_pkg::ST_IDLE;
      endcase
   end
endmodule
